/* design/ltr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltr_pkg
// Shared types, codes and constants of the log trace ring.
// ----------------------------------------------------------------------------
package ltr_pkg;

   // default sizes
   localparam int RING_BYTES_DEF = 8192;
   localparam int LINE_LIMIT_DEF = 200;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 14;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;

   // characters of interest
   localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_CSI      = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_FINAL_LO = 8'h40;
   localparam logic [BYTE_W-1:0] CH_FINAL_HI = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_NL       = 8'h0A;

   typedef enum logic [1:0] {
      CMD_APPEND    = 2'd0,
      CMD_CHUNK_END = 2'd1,
      CMD_SNAPSHOT  = 2'd2,
      CMD_READ      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_COUNT = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_NONE  = 2'd2
   } kind_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_DEC = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic              append;
      logic              chunk_end;
      logic [BYTE_W-1:0] data;
   } filt_req_type;

endpackage

/* design/ltr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ltr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ltr_esc_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltr_esc_filter
// Per-chunk line limit and ANSI escape removal; flags bytes to keep.
// ----------------------------------------------------------------------------
module ltr_esc_filter #(
   parameter int LINE_LIMIT = ltr_pkg::LINE_LIMIT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ltr_pkg::filt_req_type req,
   output logic                 keep
);

   localparam int CW = $clog2(LINE_LIMIT);
   localparam logic [CW-1:0] LIMIT_M1 = CW'(LINE_LIMIT - 1);

   typedef enum logic [2:0] {
      PH_TEXT = 3'b001,
      PH_ESC  = 3'b010,
      PH_CSI  = 3'b100
   } phase_type;

   logic [CW-1:0] cnt_ff, cnt_in;
   phase_type     phase_ff, phase_in;

   always_comb begin
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      keep     = 1'b0;
      if (req.chunk_end) begin
         cnt_in   = '0;
         phase_in = PH_TEXT;
      end else if (req.append && (cnt_ff < LIMIT_M1)) begin
         cnt_in = cnt_ff + 1'b1;
         unique case (phase_ff)
            PH_ESC: begin
               phase_in = (req.data == ltr_pkg::CH_CSI) ? PH_CSI : PH_TEXT;
            end
            PH_CSI: begin
               if ((req.data >= ltr_pkg::CH_FINAL_LO) &&
                   (req.data <= ltr_pkg::CH_FINAL_HI)) begin
                  phase_in = PH_TEXT;
               end
            end
            PH_TEXT: begin
               if (req.data == ltr_pkg::CH_ESC) begin
                  phase_in = PH_ESC;
               end else begin
                  keep = 1'b1;
               end
            end
            default: begin
               phase_in = PH_TEXT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         phase_ff <= PH_TEXT;
      end else begin
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* design/ltr_ring_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltr_ring_alu
// Shared ring address unit: modular add or wrapping decrement.
// ----------------------------------------------------------------------------
module ltr_ring_alu #(
   parameter int RING_BYTES = ltr_pkg::RING_BYTES_DEF
) (
   input  ltr_pkg::alu_op_type          op,
   input  logic [$clog2(RING_BYTES)-1:0] base,
   input  logic [$clog2(RING_BYTES)-1:0] off,
   output logic [$clog2(RING_BYTES)-1:0] res,
   output logic                          wrap
);

   localparam int AW = $clog2(RING_BYTES);
   localparam logic [AW:0] RING_W = (AW+1)'(RING_BYTES);

   logic [AW:0] sum;

   always_comb begin
      sum  = {1'b0, base} + {1'b0, off};
      wrap = 1'b0;
      unique case (op)
         ltr_pkg::ALU_ADD: begin
            wrap = (sum >= RING_W);
            res  = wrap ? AW'(sum - RING_W) : AW'(sum);
         end
         ltr_pkg::ALU_DEC: begin
            res = (base == '0) ? AW'(RING_BYTES - 1) : base - 1'b1;
         end
         default: begin
            res = base;
         end
      endcase
   end

endmodule

/* design/log_trace_ring_with_escape_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_trace_ring_with_escape_filter
// Byte ring for filtered log text with snapshot and oldest-first readout.
// ----------------------------------------------------------------------------
//  channel | dir | tuser          | tdata (low bit up)                   | tlast
//  req_    | in  | cmd [1:0]      | data_byte 8, tail_count 14,          | -
//          |     |                | buffer_size 14, pad 4                |
//  rsp_    | out | kind [1:0]     | byte_count 14, out_byte 8, pad 2     | is_last
//
//  Append and end of chunk are taken in idle and keep req_tready high. A
//  read does the RAM access, then the output register load. A snapshot with
//  a tail count scans backwards, a read then a check state per byte, through
//  the single RAM read port feeding the newline compare. req_tready is low while
//  a command is in progress or its result waits for the output register.
//  Reset clears pointers and filter state; the ring is not cleared.
// ----------------------------------------------------------------------------
module log_trace_ring_with_escape_filter #(
   parameter int RING_BYTES = ltr_pkg::RING_BYTES_DEF,
   parameter int LINE_LIMIT = ltr_pkg::LINE_LIMIT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // data_byte [7:0], tail_count [21:8], buffer_size [35:22], zero [39:36]
   input  logic [ltr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // byte_count [13:0], out_byte [21:14], zero [23:22]
   output logic [ltr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // kind [1:0]
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int AW    = $clog2(RING_BYTES);
   localparam int CNT_W = AW + 1;
   localparam int CW    = ltr_pkg::COUNT_W;
   localparam int CMP_W = (CNT_W > CW) ? CNT_W : CW;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_SCAN_RD  = 4'b0010,
      ST_SCAN_CHK = 4'b0100,
      ST_POST     = 4'b1000
   } state_type;

   // request fields
   ltr_pkg::cmd_type           cmd;
   logic [ltr_pkg::BYTE_W-1:0] data_byte;
   logic [CW-1:0]              tail_count;
   logic [CW-1:0]              buffer_size;
   logic                       req_accept;

   assign cmd         = ltr_pkg::cmd_type'(req_tuser);
   assign data_byte   = req_tdata[7:0];
   assign tail_count  = req_tdata[21:8];
   assign buffer_size = req_tdata[35:22];

   // registers
   state_type                  state_ff, state_in;
   logic [AW-1:0]              head_ff, head_in;
   logic                       wrapped_ff, wrapped_in;
   logic [AW-1:0]              rp_ff, rp_in;
   logic [CW-1:0]              rem_ff, rem_in;
   logic [CW-1:0]              tail_ff, tail_in;
   logic [CW-1:0]              cap_ff, cap_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              seen_ff, seen_in;
   logic [AW-1:0]              scan_pos_ff, scan_pos_in;
   ltr_pkg::kind_type          pend_kind_ff, pend_kind_in;
   logic [CW-1:0]              pend_count_ff, pend_count_in;
   logic                       pend_last_ff, pend_last_in;
   logic                       pend_ram_ff, pend_ram_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ltr_pkg::kind_type          rsp_kind_ff, rsp_kind_in;
   logic [CW-1:0]              rsp_count_ff, rsp_count_in;
   logic [ltr_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                       rsp_last_ff, rsp_last_in;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;

   // filter
   ltr_pkg::filt_req_type filt_req;
   logic                  keep;

   assign filt_req.append    = req_accept && (cmd == ltr_pkg::CMD_APPEND);
   assign filt_req.chunk_end = req_accept && (cmd == ltr_pkg::CMD_CHUNK_END);
   assign filt_req.data      = data_byte;

   ltr_esc_filter #(
      .LINE_LIMIT(LINE_LIMIT)
   ) u_filter (
      .clock (clock),
      .reset (reset),
      .req   (filt_req),
      .keep  (keep)
   );

   // shared ring address unit
   ltr_pkg::alu_op_type alu_op;
   logic [AW-1:0]       alu_base;
   logic [AW-1:0]       alu_off;
   logic [AW-1:0]       alu_res;
   logic                alu_wrap;

   ltr_ring_alu #(
      .RING_BYTES(RING_BYTES)
   ) u_alu (
      .op   (alu_op),
      .base (alu_base),
      .off  (alu_off),
      .res  (alu_res),
      .wrap (alu_wrap)
   );

   // ring memory
   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [AW-1:0]              ram_rd_addr;
   logic [ltr_pkg::BYTE_W-1:0] ram_rd_data;

   assign ram_wr_en = filt_req.append && keep;

   ltr_ram #(
      .WIDTH(ltr_pkg::BYTE_W),
      .DEPTH(RING_BYTES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (head_ff),
      .wr_data (data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // snapshot window
   logic [AW-1:0]    start_w;
   logic [CNT_W-1:0] avail_w;
   logic [CW-1:0]    bufm1_w;
   logic [CW-1:0]    cap_w;
   logic             is_nl;
   logic             scan_stop;
   logic             rsp_load;

   always_comb begin
      start_w = wrapped_ff ? head_ff : '0;
      avail_w = wrapped_ff ? CNT_W'(RING_BYTES) : {1'b0, head_ff};
      bufm1_w = buffer_size - 1'b1;
      cap_w   = (CMP_W'(avail_w) > CMP_W'(bufm1_w)) ? bufm1_w : CW'(avail_w);
   end

   assign is_nl     = (ram_rd_data == ltr_pkg::CH_NL);
   assign scan_stop = is_nl && (seen_ff == tail_ff);
   assign rsp_load  = !rsp_valid_ff || rsp_tready;

   // address unit and read port selection
   always_comb begin
      alu_op      = ltr_pkg::ALU_ADD;
      alu_base    = head_ff;
      alu_off     = AW'(1);
      ram_rd_en   = 1'b0;
      ram_rd_addr = rp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd == ltr_pkg::CMD_SNAPSHOT) begin
               alu_base = start_w;
               alu_off  = AW'(cap_w - 1'b1);
            end else if (cmd == ltr_pkg::CMD_READ) begin
               alu_base  = rp_ff;
               ram_rd_en = req_accept && (rem_ff != '0);
            end
         end
         ST_SCAN_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_pos_ff;
         end
         ST_SCAN_CHK: begin
            alu_base = scan_pos_ff;
            if (!scan_stop) begin
               alu_op = ltr_pkg::ALU_DEC;
            end
         end
         ST_POST: begin
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      wrapped_in    = wrapped_ff;
      rp_in         = rp_ff;
      rem_in        = rem_ff;
      tail_in       = tail_ff;
      cap_in        = cap_ff;
      idx_in        = idx_ff;
      seen_in       = seen_ff;
      scan_pos_in   = scan_pos_ff;
      pend_kind_in  = pend_kind_ff;
      pend_count_in = pend_count_ff;
      pend_last_in  = pend_last_ff;
      pend_ram_in   = pend_ram_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (cmd)
                  ltr_pkg::CMD_APPEND: begin
                     if (keep) begin
                        head_in    = alu_res;
                        wrapped_in = wrapped_ff || alu_wrap;
                     end
                  end
                  ltr_pkg::CMD_CHUNK_END: begin
                  end
                  ltr_pkg::CMD_SNAPSHOT: begin
                     tail_in      = tail_count;
                     pend_kind_in = ltr_pkg::KIND_COUNT;
                     pend_last_in = 1'b0;
                     pend_ram_in  = 1'b0;
                     if (buffer_size == '0) begin
                        rp_in         = start_w;
                        rem_in        = '0;
                        pend_count_in = '0;
                        state_in      = ST_POST;
                     end else if ((tail_count == '0) || (cap_w == '0)) begin
                        rp_in         = start_w;
                        rem_in        = cap_w;
                        pend_count_in = cap_w;
                        state_in      = ST_POST;
                     end else begin
                        cap_in      = cap_w;
                        idx_in      = cap_w;
                        seen_in     = '0;
                        scan_pos_in = alu_res;
                        state_in    = ST_SCAN_RD;
                     end
                  end
                  ltr_pkg::CMD_READ: begin
                     pend_count_in = '0;
                     if (rem_ff == '0) begin
                        pend_kind_in = ltr_pkg::KIND_NONE;
                        pend_last_in = 1'b0;
                        pend_ram_in  = 1'b0;
                     end else begin
                        rp_in        = alu_res;
                        rem_in       = rem_ff - 1'b1;
                        pend_kind_in = ltr_pkg::KIND_DATA;
                        pend_last_in = (rem_ff == CW'(1));
                        pend_ram_in  = 1'b1;
                     end
                     state_in = ST_POST;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (scan_stop) begin
               // newline beyond the requested tail: start just after it
               rp_in         = alu_res;
               rem_in        = cap_ff - idx_ff;
               pend_count_in = cap_ff - idx_ff;
               state_in      = ST_POST;
            end else begin
               seen_in = seen_ff + CW'(is_nl);
               if (idx_ff == CW'(1)) begin
                  rp_in         = scan_pos_ff;
                  rem_in        = cap_ff;
                  pend_count_in = cap_ff;
                  state_in      = ST_POST;
               end else begin
                  idx_in      = idx_ff - 1'b1;
                  scan_pos_in = alu_res;
                  state_in    = ST_SCAN_RD;
               end
            end
         end
         ST_POST: begin
            // hold the result until the output register is free
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_count_in = pend_count_ff;
               rsp_byte_in  = pend_ram_ff ? ram_rd_data : '0;
               rsp_last_in  = pend_last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         wrapped_ff   <= 1'b0;
         rp_ff        <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         wrapped_ff   <= wrapped_in;
         rp_ff        <= rp_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff       <= tail_in;
      cap_ff        <= cap_in;
      idx_ff        <= idx_in;
      seen_ff       <= seen_in;
      scan_pos_ff   <= scan_pos_in;
      pend_kind_ff  <= pend_kind_in;
      pend_count_ff <= pend_count_in;
      pend_last_ff  <= pend_last_in;
      pend_ram_ff   <= pend_ram_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_byte_ff, rsp_count_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* design/ltr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltr_checker
// Port-level checks of the log trace ring, bound to the top level.
// ----------------------------------------------------------------------------
module ltr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [1:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ltr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tlast
);

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // appends and chunk ends never stall the next item
   a_fast_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      ((req_tuser == ltr_pkg::CMD_APPEND) || (req_tuser == ltr_pkg::CMD_CHUNK_END))
      |=> req_tready)
      else $error("ready lost after append or chunk end");

   // last flag only on data bytes
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == ltr_pkg::KIND_DATA)
      else $error("last flag on non-data result");

   // count field is zero except on snapshot results
   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ltr_pkg::KIND_COUNT) |-> rsp_tdata[13:0] == 14'd0)
      else $error("byte count on non-count result");

   // no byte value on count or empty results
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ltr_pkg::KIND_DATA) |-> rsp_tdata[21:14] == 8'd0)
      else $error("data byte on non-data result");

endmodule

bind log_trace_ring_with_escape_filter ltr_checker u_ltr_checker (.*);
